@@ hdl/aspool_pkg.sv @@
// Shared types and constants for the aging slot pool.
// Used by aspool_age_unit, aspool_seq and the top level; no dependencies.
`default_nettype none

package aspool_pkg;

   localparam int AGE_W        = 24;
   localparam int SLOT_FIELD_W = 5;
   localparam int MASK_W       = 32;
   localparam int EXTRA_W      = 76;

   localparam logic [AGE_W-1:0] AGE_MAX         = 24'hFF_FFFF;
   localparam logic [AGE_W-1:0] GRACE_AGE_LIMIT = 24'd100;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] GRACE_NONE  = 2'd0;
   localparam logic [1:0] GRACE_ARMED = 2'd1;
   localparam logic [1:0] GRACE_LAST  = 2'd2;

   // floor(lifetime * 7 / 20) as (lifetime * GRACE_MUL) >> GRACE_SHIFT
   localparam int               GRACE_SHIFT = 30;
   localparam logic [28:0]      GRACE_MUL   = 29'd375809639;
   localparam int               PROD_W      = AGE_W + GRACE_SHIFT;

   typedef struct packed {
      logic        operation;
      logic [23:0] elapsed;
      logic [23:0] start_age;
      logic [23:0] lifetime;
      logic        grace_style;
      logic [31:0] payload_tag;
      logic        follow_muzzle;
      logic [2:0]  weapon_kind;
      logic [31:0] seed;
      logic [7:0]  player_index;
   } req_type;

   typedef struct packed {
      logic [4:0]  chosen_slot;
      logic        evicted;
      logic [31:0] active_mask;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic s1_valid;
      logic s2_valid;
      logic commit;
      logic finish;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ hdl/aspool_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module aspool_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/aspool_age_unit.sv @@
// Shared per-slot unit: saturating age update, expiry and grace decision,
// grace age multiply, and oldest/free slot search. Depends on aspool_pkg.
`default_nettype none

module aspool_age_unit #(
   parameter int POOL_SLOTS = 32,
   localparam int IW = $clog2(POOL_SLOTS)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire aspool_pkg::ctl_type          ctl,
   input  wire logic [IW-1:0]                s1_idx,
   input  wire logic                         op_tick,
   input  wire logic [aspool_pkg::AGE_W-1:0] elapsed,
   input  wire logic [aspool_pkg::AGE_W-1:0] age_q,
   input  wire logic [aspool_pkg::AGE_W-1:0] life_q,
   input  wire logic                         slot_act,
   input  wire logic [1:0]                   slot_grace,
   output logic                              act_next,
   output logic [1:0]                        grace_next,
   output logic                              wr_en,
   output logic [aspool_pkg::AGE_W-1:0]      wr_age,
   output logic [IW-1:0]                     chosen_idx,
   output logic                              evict
);

   logic [aspool_pkg::AGE_W:0]        sum;
   logic [aspool_pkg::AGE_W-1:0]      sat;
   logic                              expire;
   logic                              grace_path;
   logic [aspool_pkg::PROD_W-1:0]     prod;

   logic                              wr_en_ff, wr_en_in;
   logic                              sel_ff, sel_in;
   logic [aspool_pkg::AGE_W-1:0]      sat_ff, sat_in;
   logic [aspool_pkg::AGE_W-1:0]      gage_ff, gage_in;

   logic [aspool_pkg::AGE_W-1:0]      best_age_ff, best_age_in;
   logic [IW-1:0]                     best_idx_ff, best_idx_in;
   logic                              free_found_ff, free_found_in;
   logic [IW-1:0]                     free_idx_ff, free_idx_in;

   assign sum        = {1'b0, age_q} + {1'b0, elapsed};
   assign sat        = sum[aspool_pkg::AGE_W] ? aspool_pkg::AGE_MAX
                                              : sum[aspool_pkg::AGE_W-1:0];
   assign expire     = (sat >= life_q);
   assign grace_path = (slot_grace == aspool_pkg::GRACE_ARMED) &&
                       (age_q <= aspool_pkg::GRACE_AGE_LIMIT);
   assign prod       = aspool_pkg::PROD_W'(life_q) * aspool_pkg::PROD_W'(aspool_pkg::GRACE_MUL);

   always_comb begin
      act_next   = slot_act;
      grace_next = slot_grace;
      if (slot_act) begin
         if (slot_grace == aspool_pkg::GRACE_LAST) begin
            act_next = 1'b0;
         end else if (expire) begin
            if (grace_path) begin
               grace_next = aspool_pkg::GRACE_LAST;
            end else begin
               act_next = 1'b0;
            end
         end else if (slot_grace == aspool_pkg::GRACE_ARMED) begin
            grace_next = aspool_pkg::GRACE_NONE;
         end
      end
   end

   always_comb begin
      wr_en_in = ctl.s1_valid && op_tick && slot_act &&
                 (slot_grace != aspool_pkg::GRACE_LAST);
      sel_in   = expire && grace_path;
      sat_in   = sat;
      gage_in  = prod[aspool_pkg::GRACE_SHIFT +: aspool_pkg::AGE_W];
   end

   always_comb begin
      best_age_in   = best_age_ff;
      best_idx_in   = best_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (ctl.s1_valid && !op_tick) begin
         if (s1_idx == '0) begin
            best_age_in   = age_q;
            best_idx_in   = '0;
            free_found_in = !slot_act;
            free_idx_in   = '0;
         end else begin
            if (age_q > best_age_ff) begin
               best_age_in = age_q;
               best_idx_in = s1_idx;
            end
            if (!free_found_ff && !slot_act) begin
               free_found_in = 1'b1;
               free_idx_in   = s1_idx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= wr_en_in;
      end
      sel_ff        <= sel_in;
      sat_ff        <= sat_in;
      gage_ff       <= gage_in;
      best_age_ff   <= best_age_in;
      best_idx_ff   <= best_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

   assign wr_en      = wr_en_ff;
   assign wr_age     = sel_ff ? gage_ff : sat_ff;
   assign chosen_idx = free_found_ff ? free_idx_ff : best_idx_ff;
   assign evict      = !free_found_ff;

endmodule

`default_nettype wire

@@ hdl/aspool_seq.sv @@
// Sequencer: request handshake, slot walk counter, pipeline valids, response valid.
// Depends on aspool_pkg.
`default_nettype none

module aspool_seq #(
   parameter int POOL_SLOTS = 32,
   localparam int IW = $clog2(POOL_SLOTS),
   localparam int CW = $clog2(POOL_SLOTS + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                op_tick,
   input  wire logic                rsp_stall,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output aspool_pkg::ctl_type      ctl,
   output logic [IW-1:0]            rd_idx,
   output logic [IW-1:0]            s1_idx,
   output logic [IW-1:0]            s2_idx
);

   aspool_pkg::state_type state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic                  s2_vld_ff, s2_vld_in;
   logic [IW-1:0]         s1_idx_ff, s1_idx_in;
   logic [IW-1:0]         s2_idx_ff, s2_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  walk_done;

   assign walk_done = (cnt_ff == CW'(POOL_SLOTS)) && !s1_vld_ff && !s2_vld_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aspool_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = aspool_pkg::ST_SCAN;
            end
         end
         aspool_pkg::ST_SCAN: begin
            if (walk_done) begin
               state_in = op_tick ? aspool_pkg::ST_DONE : aspool_pkg::ST_COMMIT;
            end
         end
         aspool_pkg::ST_COMMIT: begin
            state_in = aspool_pkg::ST_DONE;
         end
         aspool_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = aspool_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aspool_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != aspool_pkg::ST_IDLE);
      ctl.accept   = req_valid && (state_ff == aspool_pkg::ST_IDLE);
      ctl.issue    = (state_ff == aspool_pkg::ST_SCAN) && (cnt_ff < CW'(POOL_SLOTS));
      ctl.s1_valid = s1_vld_ff;
      ctl.s2_valid = s2_vld_ff;
      ctl.commit   = (state_ff == aspool_pkg::ST_COMMIT);
      ctl.finish   = (state_ff == aspool_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      cnt_in       = cnt_ff;
      if (ctl.accept) begin
         cnt_in = '0;
      end else if (ctl.issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
      s1_vld_in    = ctl.issue;
      s1_idx_in    = cnt_ff[IW-1:0];
      s2_vld_in    = s1_vld_ff;
      s2_idx_in    = s1_idx_ff;
      rsp_valid_in = ctl.finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aspool_pkg::ST_IDLE;
         cnt_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_idx_ff <= s1_idx_in;
      s2_idx_ff <= s2_idx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rd_idx    = cnt_ff[IW-1:0];
   assign s1_idx    = s1_idx_ff;
   assign s2_idx    = s2_idx_ff;

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> (state_ff == aspool_pkg::ST_IDLE) && rsp_valid_ff)
      else $error("finish did not load the response");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aspool_pkg::ST_IDLE) |-> !s1_vld_ff && !s2_vld_ff)
      else $error("slot pipeline busy while idle");

   a_commit_after_walk: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (cnt_ff == CW'(POOL_SLOTS)) && $past(state_ff == aspool_pkg::ST_SCAN))
      else $error("commit before the slot walk finished");

endmodule

`default_nettype wire

@@ hdl/aging_slot_pool_oldest_eviction_unit.sv @@
// Top level of the aging slot pool with oldest-slot eviction.
// Depends on aspool_pkg, aspool_ram, aspool_age_unit and aspool_seq.
//
// Each request walks every slot once, one slot per cycle, through the age
// memory's read port and the shared age unit; the next request is taken
// only once the walk, commit and response load are done. The response
// sits in an output register, so a new request is taken while it waits.
// An add takes the lowest free slot, or the first oldest slot when the pool
// is full; a tick ages, expires and grace-handles every active slot.
`default_nettype none

module aging_slot_pool_oldest_eviction_unit #(
   parameter int POOL_SLOTS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire aspool_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output aspool_pkg::rsp_type      rsp_data
);

   localparam int IW = $clog2(POOL_SLOTS);

   aspool_pkg::ctl_type           ctl;
   logic [IW-1:0]                 rd_idx, s1_idx, s2_idx, chosen_idx;
   aspool_pkg::req_type           req_ff, req_in;
   aspool_pkg::rsp_type           rsp_ff, rsp_in;
   logic [POOL_SLOTS-1:0]         active_ff, active_in;
   logic [1:0]                    grace_ff [POOL_SLOTS];
   logic [1:0]                    grace_in [POOL_SLOTS];
   logic [aspool_pkg::AGE_W-1:0]  age_q, life_q, wr_age;
   logic                          act_next, wr_en, evict;
   logic [1:0]                    grace_next;
   logic                          op_tick;
   logic                          age_we;
   logic [IW-1:0]                 age_waddr;
   logic [aspool_pkg::AGE_W-1:0]  age_wdata;
   logic [aspool_pkg::EXTRA_W-1:0] extra_wdata;
   logic [aspool_pkg::MASK_W-1:0] mask;

   assign op_tick = (req_ff.operation == aspool_pkg::OP_TICK);

   aspool_seq #(.POOL_SLOTS(POOL_SLOTS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .op_tick   (op_tick),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .rd_idx    (rd_idx),
      .s1_idx    (s1_idx),
      .s2_idx    (s2_idx)
   );

   aspool_age_unit #(.POOL_SLOTS(POOL_SLOTS)) u_age (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .s1_idx     (s1_idx),
      .op_tick    (op_tick),
      .elapsed    (req_ff.elapsed),
      .age_q      (age_q),
      .life_q     (life_q),
      .slot_act   (active_ff[s1_idx]),
      .slot_grace (grace_ff[s1_idx]),
      .act_next   (act_next),
      .grace_next (grace_next),
      .wr_en      (wr_en),
      .wr_age     (wr_age),
      .chosen_idx (chosen_idx),
      .evict      (evict)
   );

   always_comb begin
      age_we    = ctl.commit || (ctl.s2_valid && wr_en);
      age_waddr = ctl.commit ? chosen_idx : s2_idx;
      age_wdata = ctl.commit ? req_ff.start_age : wr_age;
      extra_wdata = {req_ff.payload_tag, req_ff.player_index, req_ff.seed,
                     req_ff.weapon_kind, req_ff.follow_muzzle};
   end

   aspool_ram #(.WIDTH(aspool_pkg::AGE_W), .DEPTH(POOL_SLOTS)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_wdata),
      .rd_addr (rd_idx),
      .rd_data (age_q)
   );

   aspool_ram #(.WIDTH(aspool_pkg::AGE_W), .DEPTH(POOL_SLOTS)) u_life_ram (
      .clock   (clock),
      .wr_en   (ctl.commit),
      .wr_addr (chosen_idx),
      .wr_data (req_ff.lifetime),
      .rd_addr (rd_idx),
      .rd_data (life_q)
   );

   aspool_ram #(.WIDTH(aspool_pkg::EXTRA_W), .DEPTH(POOL_SLOTS)) u_extra_ram (
      .clock   (clock),
      .wr_en   (ctl.commit),
      .wr_addr (chosen_idx),
      .wr_data (extra_wdata),
      .rd_addr (rd_idx),
      .rd_data ()
   );

   always_comb begin
      active_in = active_ff;
      grace_in  = grace_ff;
      if (ctl.s1_valid && op_tick) begin
         active_in[s1_idx] = act_next;
         grace_in[s1_idx]  = grace_next;
      end
      if (ctl.commit) begin
         active_in[chosen_idx] = 1'b1;
         grace_in[chosen_idx]  = {1'b0, req_ff.grace_style};
      end
   end

   for (genvar i = 0; i < aspool_pkg::MASK_W; i++) begin : g_mask
      if (i < POOL_SLOTS) begin : g_on
         assign mask[i] = active_ff[i];
      end else begin : g_off
         assign mask[i] = 1'b0;
      end
   end

   always_comb begin
      req_in = ctl.accept ? req_data : req_ff;
      rsp_in = rsp_ff;
      if (ctl.finish) begin
         rsp_in.chosen_slot = op_tick ? '0 : aspool_pkg::SLOT_FIELD_W'(chosen_idx);
         rsp_in.evicted     = op_tick ? 1'b0 : evict;
         rsp_in.active_mask = mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < POOL_SLOTS; i++) begin
            grace_ff[i] <= aspool_pkg::GRACE_NONE;
         end
      end else begin
         active_ff <= active_in;
         grace_ff  <= grace_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   a_commit_sets_active: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> active_ff[$past(chosen_idx)])
      else $error("added slot not active");

endmodule

`default_nettype wire
